@@ hw/rtl/jasf_pkg.sv @@
// Shared types and constants for the JPEG APP segment finder.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package jasf_pkg;

    // Stream and magic limits.
    localparam int unsigned MAX_STREAM_BYTES = 16777216;
    localparam int unsigned MAX_MAGIC_BYTES  = 8;

    // Byte position holds values up to MAX_STREAM_BYTES inclusive (saturating).
    localparam int unsigned POS_W       = $clog2(MAX_STREAM_BYTES) + 1;
    localparam int unsigned START_W     = POS_W - 1;
    localparam int unsigned MAGIC_IDX_W = (MAX_MAGIC_BYTES > 1) ? $clog2(MAX_MAGIC_BYTES) : 1;

    // Fixed field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MLEN_W   = 4;
    localparam int unsigned MAGIC_W  = 64;
    localparam int unsigned OFFSET_W = 25;
    localparam int unsigned LEN_W    = 16;

    // Configuration port.
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned APB_ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_SOUGHT_CODE = 2'd0,
        REG_MAGIC_COUNT = 2'd1,
        REG_MAGIC_BYTES = 2'd2
    } reg_idx_t;

    // Marker codes.
    localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0] MARK_SOI    = 8'hD8;
    localparam logic [BYTE_W-1:0] MARK_EOI    = 8'hD9;

    // Payload offset relative to the 0xFF prefix (prefix, code, two length bytes).
    localparam int unsigned HEADER_BYTES = 4;
    // The declared length counts its own two bytes.
    localparam int unsigned LEN_FIELD_BYTES = 2;

    localparam logic [BYTE_W-1:0] SOUGHT_CODE_RESET = 8'hE1;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_MARKER  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  sought_code;
        logic [MLEN_W-1:0]  magic_count;
        logic [MAGIC_W-1:0] magic_bytes;
    } cfg_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] segment_offset;
        logic [LEN_W-1:0]    segment_length;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/jpeg_app_segment_finder.sv @@
// Top level of the JPEG APP segment finder: input register, walker, result register.
// Depends on jasf_pkg, jasf_apb_regs and jasf_parser.
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------------------
// input     | in        | in_valid/in_ready   | data_byte[7:0], last
// result    | out       | out_valid/out_ready | found, segment_offset[24:0],
//           |           |                     | segment_length[15:0]
// config    | in        | APB psel/penable    | paddr[4:0], pwdata[63:0], prdata[63:0]
//
// Each request is held in the input register and is processed by the walker as it
// leaves that register, so the block sustains one byte per clock while results are taken.
// A result lands in the output register in the cycle after the walker processes its byte.
// Reset clears the walker to "expect 0xFF prefix" and loads the register defaults.
// When a result waits in the output register and out_ready is low, the walker holds and
// in_ready drops once the input register is occupied; no request is lost or repeated.
// Registers are at byte addresses 0 (sought marker code), 8 (magic byte count) and
// 16 (magic bytes).

module jpeg_app_segment_finder
    import jasf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [BYTE_W-1:0]     data_byte,
    input  wire logic                  last,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       found,
    output logic      [OFFSET_W-1:0]   segment_offset,
    output logic      [LEN_W-1:0]      segment_length,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t              cfg;
    res_t              res;
    logic              emit;

    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;

    logic              out_vld_reg, out_vld_next;
    res_t              out_res_reg;

    jasf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The walker consumes the held byte whenever the result register can take a result.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    jasf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .cfg       (cfg),
        .emit      (emit),
        .res       (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && emit)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last;
        end
        if (advance && emit)
            out_res_reg <= res;
    end

    assign out_valid      = out_vld_reg;
    assign found          = out_res_reg.found;
    assign segment_offset = out_res_reg.segment_offset;
    assign segment_length = out_res_reg.segment_length;

endmodule

`default_nettype wire

@@ hw/rtl/jasf_apb_regs.sv @@
// Configuration register file behind an APB-style port.
// Depends on jasf_pkg for the register map and the cfg_t bundle.
`default_nettype none

module jasf_apb_regs
    import jasf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sought_code <= SOUGHT_CODE_RESET;
            cfg_reg.magic_count <= '0;
            cfg_reg.magic_bytes <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SOUGHT_CODE: cfg_reg.sought_code <= pwdata[BYTE_W-1:0];
                REG_MAGIC_COUNT: cfg_reg.magic_count <= pwdata[MLEN_W-1:0];
                REG_MAGIC_BYTES: cfg_reg.magic_bytes <= pwdata[MAGIC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SOUGHT_CODE: prdata = APB_DATA_W'(cfg_reg.sought_code);
            REG_MAGIC_COUNT: prdata = APB_DATA_W'(cfg_reg.magic_count);
            REG_MAGIC_BYTES: prdata = APB_DATA_W'(cfg_reg.magic_bytes);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/jasf_parser.sv @@
// Marker segment walker: per-byte state machine and the match decision.
// Depends on jasf_pkg for phase_t, cfg_t, res_t and the stream constants.
`default_nettype none

module jasf_parser
    import jasf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last,
    input  wire cfg_t              cfg,
    output logic                   emit,
    output res_t                   res
);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]    span_reg, span_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   marker_reg, marker_next;
    logic [BYTE_W-1:0]   len_hi_reg, len_hi_next;
    logic                magic_ok_reg, magic_ok_next;
    logic                given_reg, given_next;

    logic                overflow;
    logic                active;
    logic [MLEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]    declared;
    logic                short_len;
    logic                cand;
    logic                span_zero;
    logic [BYTE_W-1:0]   magic_byte;
    logic                magic_ok_pl;
    logic                payload_end;
    logic                dec;
    logic                fnd;

    // Shared decode of the current byte.
    assign overflow  = pos_reg[POS_W-1];
    assign active    = step && !given_reg && !overflow;
    assign eff_len   = (cfg.magic_count > MLEN_W'(MAX_MAGIC_BYTES))
                       ? MLEN_W'(MAX_MAGIC_BYTES) : cfg.magic_count;
    assign declared  = {len_hi_reg, data_byte};
    assign short_len = declared < LEN_W'(LEN_FIELD_BYTES);
    assign cand      = (marker_reg == cfg.sought_code)
                       && (declared >= LEN_W'(eff_len) + LEN_W'(LEN_FIELD_BYTES));
    assign span_zero = declared == LEN_W'(LEN_FIELD_BYTES);
    assign magic_byte  = cfg.magic_bytes[idx_reg[MAGIC_IDX_W-1:0]*BYTE_W +: BYTE_W];
    assign magic_ok_pl = magic_ok_reg
                         && !((idx_reg < LEN_W'(eff_len)) && (data_byte != magic_byte));
    assign payload_end = ({1'b0, idx_reg} + (LEN_W+1)'(1)) >= {1'b0, span_reg};

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step && last)
        begin
            phase_next = PH_PREFIX;
        end
        else if (active)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (data_byte == MARK_PREFIX)
                        phase_next = PH_MARKER;
                end
                PH_MARKER:
                begin
                    if (data_byte == MARK_SOI)
                        phase_next = PH_PREFIX;
                    else if (data_byte != MARK_EOI)
                        phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (!short_len)
                    begin
                        if (!span_zero)
                            phase_next = PH_PAYLOAD;
                        else if (!cand)
                            phase_next = PH_PREFIX;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (payload_end && !magic_ok_pl)
                        phase_next = PH_PREFIX;
                end
                default:
                begin
                    phase_next = PH_PREFIX;
                end
            endcase
        end
    end

    // Decision and datapath updates.
    always_comb
    begin
        dec           = 1'b0;
        fnd           = 1'b0;
        start_next    = start_reg;
        span_next     = span_reg;
        idx_next      = idx_reg;
        marker_next   = marker_reg;
        len_hi_next   = len_hi_reg;
        magic_ok_next = magic_ok_reg;
        given_next    = given_reg;
        pos_next      = pos_reg;

        if (step && !given_reg && overflow)
            dec = 1'b1;

        if (active)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (data_byte != MARK_PREFIX || last)
                        dec = 1'b1;
                    else
                        start_next = pos_reg[START_W-1:0];
                end
                PH_MARKER:
                begin
                    marker_next = data_byte;
                    if (data_byte == MARK_EOI || last)
                        dec = 1'b1;
                end
                PH_LEN_HI:
                begin
                    if (last)
                        dec = 1'b1;
                    else
                        len_hi_next = data_byte;
                end
                PH_LEN_LO:
                begin
                    if (last || short_len)
                    begin
                        dec = 1'b1;
                    end
                    else
                    begin
                        span_next = declared - LEN_W'(LEN_FIELD_BYTES);
                        if (span_zero)
                        begin
                            if (cand)
                            begin
                                dec = 1'b1;
                                fnd = 1'b1;
                            end
                        end
                        else
                        begin
                            magic_ok_next = cand;
                            idx_next      = '0;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    magic_ok_next = magic_ok_pl;
                    if (last)
                    begin
                        dec = 1'b1;
                    end
                    else if (payload_end)
                    begin
                        if (magic_ok_pl)
                        begin
                            dec = 1'b1;
                            fnd = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + LEN_W'(1);
                    end
                end
                default:
                begin
                    dec = 1'b1;
                end
            endcase
        end

        if (dec)
            given_next = 1'b1;

        if (step)
        begin
            if (!overflow)
                pos_next = pos_reg + POS_W'(1);
            if (last)
            begin
                pos_next      = '0;
                start_next    = '0;
                span_next     = '0;
                idx_next      = '0;
                marker_next   = '0;
                len_hi_next   = '0;
                magic_ok_next = 1'b1;
                given_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PREFIX;
            pos_reg      <= '0;
            start_reg    <= '0;
            span_reg     <= '0;
            idx_reg      <= '0;
            marker_reg   <= '0;
            len_hi_reg   <= '0;
            magic_ok_reg <= 1'b1;
            given_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            span_reg     <= span_next;
            idx_reg      <= idx_next;
            marker_reg   <= marker_next;
            len_hi_reg   <= len_hi_next;
            magic_ok_reg <= magic_ok_next;
            given_reg    <= given_next;
        end
    end

    assign emit               = dec;
    assign res.found          = fnd;
    assign res.segment_offset = fnd ? (OFFSET_W'(start_reg) + OFFSET_W'(HEADER_BYTES))
                                    : '0;
    assign res.segment_length = (fnd && phase_reg == PH_PAYLOAD) ? span_reg : '0;

    // A stream's final byte always returns the walker to its reset state.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> pos_reg == '0 && !given_reg && phase_reg == PH_PREFIX)
        else $error("state not cleared after final byte");

    // At most one result per stream.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !given_reg)
        else $error("second result within one stream");

    // A match is only decided from a length or payload byte.
    a_found_phase: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res.found |-> phase_reg == PH_LEN_LO || phase_reg == PH_PAYLOAD)
        else $error("match decided in an unexpected phase");

    // The position counter saturates exactly at the stream limit.
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg[POS_W-1] |-> pos_reg[POS_W-2:0] == '0)
        else $error("byte position beyond saturation value");

endmodule

`default_nettype wire

@@ test/jpeg_app_segment_finder_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_app_segment_finder: byte streams in, one search result out.
// Depends on jasf_pkg and the jpeg_app_segment_finder RTL; needs nothing else to run.

module jpeg_app_segment_finder_test;
    import jasf_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    // Longest run of cycles without any handshake before the run is declared hung.
    localparam int IDLE_LIMIT = 5000;
    // Cycles that a byte may still be inside the block after the last result was taken.
    localparam int DRAIN_CYCLES = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     data_byte;
    logic                  last;
    logic                  out_valid;
    logic                  out_ready;
    logic                  found;
    logic [OFFSET_W-1:0]   segment_offset;
    logic [LEN_W-1:0]      segment_length;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    jpeg_app_segment_finder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .segment_offset (segment_offset),
        .segment_length (segment_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // The register values the block should hold, mirrored at every write.
    cfg_t live_cfg;

    // Mirror of the segment walker. It is advanced once per accepted request, in the
    // order the block accepts them, so it always reflects the stream seen so far.
    logic [OFFSET_W-1:0] scan_pos;
    logic [OFFSET_W-1:0] seg_start;
    logic [LEN_W:0]      seg_span;
    phase_t              scan_phase;
    logic [BYTE_W-1:0]   seg_marker;
    logic [BYTE_W-1:0]   len_hi;
    logic [LEN_W-1:0]    pay_idx;
    logic                magic_ok;
    logic                scan_done;

    // Search results still owed by the block, oldest first.
    res_t expected_results[$];

    int  errors;
    int  n_bytes;
    int  n_streams;
    int  n_results;
    int  n_found;
    int  n_cfg_writes;
    int  burst_left;
    bit  gaps_off;

    function automatic void clear_scan();
        scan_pos   = '0;
        seg_start  = '0;
        seg_span   = '0;
        scan_phase = PH_PREFIX;
        seg_marker = '0;
        len_hi     = '0;
        pay_idx    = '0;
        magic_ok   = 1'b1;
        scan_done  = 1'b0;
    endfunction

    // Advances the walker mirror by one stream byte. Returns 1 when this byte settles
    // the search, with the outcome in res; every later byte of the stream is absorbed.
    function automatic bit walk_byte(input logic [BYTE_W-1:0] d, input logic is_last,
                                     output res_t res);
        bit                decided;
        bit                hit;
        bit                candidate;
        logic [LEN_W-1:0]  declared;
        int unsigned       eff_len;

        decided = 1'b0;
        hit     = 1'b0;
        res     = '0;
        // Magic lengths beyond the supported maximum compare the maximum.
        eff_len = (live_cfg.magic_count > MAX_MAGIC_BYTES) ? MAX_MAGIC_BYTES
                                                           : live_cfg.magic_count;
        if (!scan_done)
        begin
            if (scan_pos >= MAX_STREAM_BYTES)
            begin
                decided = 1'b1;
            end
            else
            begin
                case (scan_phase)
                    PH_PREFIX:
                    begin
                        if (d != MARK_PREFIX || is_last)
                        begin
                            decided = 1'b1;
                        end
                        else
                        begin
                            seg_start  = scan_pos;
                            scan_phase = PH_MARKER;
                        end
                    end
                    PH_MARKER:
                    begin
                        seg_marker = d;
                        if (d == MARK_EOI || is_last)
                        begin
                            decided = 1'b1;
                        end
                        else if (d == MARK_SOI)
                        begin
                            scan_phase = PH_PREFIX;
                        end
                        else
                        begin
                            scan_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        if (is_last)
                        begin
                            decided = 1'b1;
                        end
                        else
                        begin
                            len_hi     = d;
                            scan_phase = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        declared = {len_hi, d};
                        if (is_last || declared < LEN_FIELD_BYTES)
                        begin
                            decided = 1'b1;
                        end
                        else
                        begin
                            seg_span  = (LEN_W + 1)'(declared) - (LEN_W + 1)'(LEN_FIELD_BYTES);
                            candidate = (seg_marker == live_cfg.sought_code) &&
                                        (declared >= LEN_FIELD_BYTES + eff_len);
                            if (seg_span == 0)
                            begin
                                if (candidate)
                                begin
                                    decided = 1'b1;
                                    hit     = 1'b1;
                                end
                                else
                                begin
                                    scan_phase = PH_PREFIX;
                                end
                            end
                            else
                            begin
                                magic_ok   = candidate;
                                pay_idx    = '0;
                                scan_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (magic_ok && pay_idx < eff_len &&
                            d != BYTE_W'(live_cfg.magic_bytes >> (8 * pay_idx[2:0])))
                            magic_ok = 1'b0;
                        if (is_last)
                        begin
                            decided = 1'b1;
                        end
                        else if (pay_idx + (LEN_W + 1)'(1) >= seg_span)
                        begin
                            if (magic_ok)
                            begin
                                decided = 1'b1;
                                hit     = 1'b1;
                            end
                            else
                            begin
                                scan_phase = PH_PREFIX;
                            end
                        end
                        else
                        begin
                            pay_idx = pay_idx + 1'b1;
                        end
                    end
                    default: decided = 1'b1;
                endcase
            end
            if (decided)
            begin
                res.found = hit;
                if (hit)
                begin
                    res.segment_offset = OFFSET_W'(seg_start + HEADER_BYTES);
                    res.segment_length = seg_span[LEN_W-1:0];
                end
                scan_done = 1'b1;
            end
        end
        if (scan_pos < MAX_STREAM_BYTES)
            scan_pos = scan_pos + 1'b1;
        if (is_last)
            clear_scan();
        return decided;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
                     $time, what, n_results, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset. All inputs are driven on the falling edge so the block
    // always sees settled values at the rising edge.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result side. out_ready follows its own pattern, independent of the
    // sender: stretches of always-ready, coin-flip stalls and a periodic stall.
    // ------------------------------------------------------------------------
    initial
    begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                0:       out_ready = 1'b1;
                1:       out_ready = 1'($urandom_range(0, 1));
                default: out_ready = (tick % 9) < 5;
            endcase
        end
    end

    // Each result taken by the receiver is compared with the oldest owed result.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, %s%0b offset=%0h length=%0h",
                         $time, "actual found=", found, segment_offset, segment_length);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("segment_offset", 32'(want.segment_offset), 32'(segment_offset));
                check_field("segment_length", 32'(want.segment_length), 32'(segment_length));
                if (want.found)
                    n_found++;
            end
        end
    end

    // A hung block shows up as a long run of cycles in which no request, no
    // result and no register write goes through.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, IDLE_LIMIT, expected_results.size());
        $display("jpeg_app_segment_finder_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request and register traffic. Every task below starts and ends right
    // after a falling edge.
    // ------------------------------------------------------------------------

    // Offers one stream byte and waits until the block takes it. The sender
    // works in bursts; between bursts it drops valid for a random gap. Within a
    // burst valid stays high and only the payload moves on.
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
        int   gap;
        res_t outcome;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if (!gaps_off)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap = $urandom_range(0, 2);
                    5, 6, 7, 8:    gap = $urandom_range(1, 6);
                    default:       gap = $urandom_range(8, 25);
                endcase
                if (gap != 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        burst_left--;
        in_valid  = 1'b1;
        data_byte = value;
        last      = is_last;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (walk_byte(value, is_last, outcome))
            expected_results.push_back(outcome);
        n_bytes++;
        @(negedge clk);
    endtask

    // Sends a whole stream, marking its final byte.
    task automatic send_stream(input byte_q_t s);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
        n_streams++;
    endtask

    // Stops offering requests and waits until the block has nothing left in flight.
    task automatic wait_idle();
        in_valid   = 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_SOUGHT_CODE: live_cfg.sought_code = value[BYTE_W-1:0];
            REG_MAGIC_COUNT: live_cfg.magic_count = value[MLEN_W-1:0];
            REG_MAGIC_BYTES: live_cfg.magic_bytes = value[MAGIC_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Waits for the block to go idle, then loads all three registers.
    task automatic load_config(input logic [BYTE_W-1:0] app, input logic [MLEN_W-1:0] mlen,
                               input logic [MAGIC_W-1:0] magic);
        wait_idle();
        write_reg(REG_SOUGHT_CODE, APB_DATA_W'(app));
        write_reg(REG_MAGIC_COUNT, APB_DATA_W'(mlen));
        write_reg(REG_MAGIC_BYTES, APB_DATA_W'(magic));
    endtask

    // Builds one random stream. Most streams are well formed: an optional SOI,
    // a few segments that mostly carry the sought marker and mostly open with
    // the magic, then an EOI, a trailing byte, a cut or nothing. The rest are
    // short runs of noise biased toward 0xFF.
    task automatic send_random_stream();
        byte_q_t             s;
        logic [BYTE_W-1:0]   mk;
        logic [LEN_W-1:0]    declared;
        int                  plen;
        int                  n_seg;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 24))
                s.push_back(($urandom_range(0, 2) == 0) ? MARK_PREFIX
                                                         : BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 1))
            begin
                s.push_back(MARK_PREFIX);
                s.push_back(MARK_SOI);
            end
            n_seg = $urandom_range(1, 4);
            for (int k = 0; k < n_seg; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: mk = live_cfg.sought_code;
                    6:                mk = MARK_PREFIX;
                    7:                mk = MARK_SOI;
                    default:          mk = BYTE_W'($urandom_range(0, 255));
                endcase
                s.push_back(MARK_PREFIX);
                s.push_back(mk);
                if (mk == MARK_SOI)
                    continue;
                plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
                                                     : $urandom_range(0, 12);
                declared = LEN_W'(plen + LEN_FIELD_BYTES);
                // Now and then a declared length too short to count itself.
                if ($urandom_range(0, 24) == 0)
                begin
                    declared = LEN_W'($urandom_range(0, 1));
                    plen     = 0;
                end
                s.push_back(declared[15:8]);
                s.push_back(declared[7:0]);
                for (int j = 0; j < plen; j++)
                    s.push_back((j < MAX_MAGIC_BYTES && $urandom_range(0, 7) != 0)
                                ? BYTE_W'(live_cfg.magic_bytes >> (8 * j))
                                : BYTE_W'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    s.push_back(MARK_PREFIX);
                    s.push_back(MARK_EOI);
                end
                5, 6:    s.push_back(BYTE_W'($urandom_range(0, 255)));
                7, 8:    s = s[0:$urandom_range(0, s.size() - 1)];
                default: ;
            endcase
            // Occasionally one byte is corrupted anywhere in the stream.
            if ($urandom_range(0, 9) == 0)
                s[$urandom_range(0, s.size() - 1)] = BYTE_W'($urandom_range(0, 255));
        end
        send_stream(s);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-picked streams under the reset register values (APP1, no magic):
    // a bad prefix, a stream ending on SOI, EOI with a byte absorbed after it,
    // a declared length too short to count itself, an empty payload that
    // matches, and a match that is cut off because no byte follows it.
    task automatic test_directed_reset_config();
        send_stream('{8'h00});
        send_stream('{MARK_PREFIX, MARK_SOI});
        send_stream('{MARK_PREFIX, MARK_EOI, 8'h00});
        send_stream('{MARK_PREFIX, SOUGHT_CODE_RESET, 8'h00, 8'h01, 8'h00});
        send_stream('{MARK_PREFIX, SOUGHT_CODE_RESET, 8'h00, 8'h02, MARK_PREFIX});
        send_stream('{MARK_PREFIX, SOUGHT_CODE_RESET, 8'h00, 8'h03, 8'h7F});
    endtask

    // A 0xFF marker code is a segment with a length, and a magic length of 15
    // compares only the first eight payload bytes.
    task automatic test_ff_marker_overlong_magic();
        load_config(MARK_PREFIX, 4'hF, '1);
        send_stream('{MARK_PREFIX, MARK_PREFIX, 8'h00, 8'h0A,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    endtask

    // Random streams under one register setting until about n requests went in.
    task automatic test_random_streams(input logic [BYTE_W-1:0] app,
                                       input logic [MLEN_W-1:0] mlen,
                                       input logic [MAGIC_W-1:0] magic,
                                       input int n, input bit back_to_back);
        int stop_at;
        load_config(app, mlen, magic);
        gaps_off = back_to_back;
        stop_at  = n_bytes + n;
        while (n_bytes < stop_at)
            send_random_stream();
        gaps_off = 1'b0;
    endtask

    // A long segment whose declared length uses both length bytes, with a full
    // eight-byte magic after an SOI, sent back to back.
    task automatic test_long_segment();
        byte_q_t            s;
        logic [MAGIC_W-1:0] magic;
        magic = {$urandom, $urandom};
        load_config(SOUGHT_CODE_RESET, 4'd8, magic);
        s = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, SOUGHT_CODE_RESET, 8'h01, 8'h00};
        for (int j = 0; j < 254; j++)
            s.push_back((j < MAX_MAGIC_BYTES) ? BYTE_W'(magic >> (8 * j))
                                              : BYTE_W'($urandom_range(0, 255)));
        s.push_back(MARK_PREFIX);
        s.push_back(MARK_EOI);
        gaps_off = 1'b1;
        send_stream(s);
        gaps_off = 1'b0;
    endtask

    initial
    begin
        errors       = 0;
        n_bytes      = 0;
        n_streams    = 0;
        n_results    = 0;
        n_found      = 0;
        n_cfg_writes = 0;
        burst_left   = 0;
        gaps_off     = 1'b0;
        live_cfg     = '{sought_code: SOUGHT_CODE_RESET, magic_count: '0, magic_bytes: '0};
        clear_scan();

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        last      = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_reset_config();
        test_ff_marker_overlong_magic();
        test_random_streams(SOUGHT_CODE_RESET, 4'd0, '0, 240, 1'b0);
        test_random_streams(8'h00, 4'd8, '1, 240, 1'b1);
        test_random_streams(MARK_PREFIX, 4'hF, {$urandom, $urandom}, 240, 1'b0);
        test_random_streams(BYTE_W'($urandom_range(0, 255)), MLEN_W'($urandom_range(0, 15)),
                            {$urandom, $urandom}, 240, 1'b0);
        test_random_streams(8'hE0, MLEN_W'($urandom_range(1, 7)), {$urandom, $urandom},
                            240, 1'b0);
        test_long_segment();

        // Nothing is owed any more; give a stray result a chance to show up.
        wait_idle();
        repeat (16) @(posedge clk);

        $display("Covered %0d streams, %0d bytes, %0d register writes.",
                 n_streams, n_bytes, n_cfg_writes);
        $display("Checked %0d results, %0d of them found segments; %0d errors.",
                 n_results, n_found, errors);
        if (errors == 0)
            $display("jpeg_app_segment_finder_test: done, clean");
        else
            $display("jpeg_app_segment_finder_test: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/jasf_pkg.sv
hw/rtl/jasf_apb_regs.sv
hw/rtl/jasf_parser.sv
hw/rtl/jpeg_app_segment_finder.sv
test/jpeg_app_segment_finder_test.sv
